### sv/eafp_pkg.sv
package eafp_pkg;

	// Scaled axis magnitude width and derived widths
	localparam int AXIS_BITS = 30;
	localparam int ZR_W = AXIS_BITS + 1;

	// CORDIC and square root depths
	localparam int CORDIC_STEPS = 24;
	localparam int SQ_STAGES = 31;
	localparam int AT_LAT = CORDIC_STEPS + 4;
	localparam int BACK_LAT = 5 + SQ_STAGES + 1 + AT_LAT;

	// Queue between front and back
	localparam int QDEPTH = 4;

	// Angle constants
	localparam logic [14:0] PI_Q13 = 15'd25736;
	localparam logic signed [27:0] PI_A24 = 28'sd52707179;

	// atan(2^-i) in units of 2^-24 rad
	localparam logic [26:0] ATAN_TAB [CORDIC_STEPS] = '{
		27'd13176795, 27'd7778716, 27'd4110060, 27'd2086331,
		27'd1047214, 27'd524117, 27'd262123, 27'd131069,
		27'd65536, 27'd32768, 27'd16384, 27'd8192,
		27'd4096, 27'd2048, 27'd1024, 27'd512,
		27'd256, 27'd128, 27'd64, 27'd32,
		27'd16, 27'd8, 27'd4, 27'd2
	};

	// Exact frame word handed from front to back
	typedef struct packed {
		logic signed [32:0] z0;
		logic signed [32:0] z1;
		logic signed [32:0] z2;
		logic signed [66:0] x0;
		logic signed [66:0] x1;
		logic signed [66:0] x2;
		logic               degen;
		logic               vert;
	} frame_t;

	// Count leading zeros of a 65-bit word, 65 when all zero
	function automatic logic [6:0] lzc65(input logic [64:0] v);
		logic [6:0] n;
		n = 7'd65;
		for (int i = 0; i < 65; i++) begin
			if (v[i]) n = 7'(64 - i);
		end
		return n;
	endfunction

endpackage

### sv/eafp_front.sv
module eafp_front import eafp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] mid_x,
	input  logic signed [31:0] mid_y,
	input  logic signed [31:0] mid_z,
	input  logic signed [31:0] up_x,
	input  logic signed [31:0] up_y,
	input  logic signed [31:0] up_z,
	input  logic signed [31:0] side_x,
	input  logic signed [31:0] side_y,
	input  logic signed [31:0] side_z,
	output logic               q_valid,
	input  logic               q_ready,
	output frame_t             word
);

	logic en;
	logic v_s1, v_s2, v_s3;
	logic signed [32:0] z_s1 [3];
	logic signed [32:0] s_s1 [3];
	logic signed [32:0] z_s2 [3];
	logic signed [65:0] p_s2 [3];
	logic signed [65:0] q_s2 [3];
	frame_t word_s3;

	// Stall the whole front while the queue is full
	assign en = q_ready;
	assign in_ready = en;
	assign q_valid = v_s3;
	assign word = word_s3;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Form z = up - mid and s = side - mid
	always_ff @(posedge clk) begin
		if (en) begin
			z_s1[0] <= 33'(up_x) - 33'(mid_x);
			z_s1[1] <= 33'(up_y) - 33'(mid_y);
			z_s1[2] <= 33'(up_z) - 33'(mid_z);
			s_s1[0] <= 33'(side_x) - 33'(mid_x);
			s_s1[1] <= 33'(side_y) - 33'(mid_y);
			s_s1[2] <= 33'(side_z) - 33'(mid_z);
		end
	end

	// Cross product partial products
	always_ff @(posedge clk) begin
		if (en) begin
			p_s2[0] <= s_s1[1] * z_s1[2];
			q_s2[0] <= s_s1[2] * z_s1[1];
			p_s2[1] <= s_s1[2] * z_s1[0];
			q_s2[1] <= s_s1[0] * z_s1[2];
			p_s2[2] <= s_s1[0] * z_s1[1];
			q_s2[2] <= s_s1[1] * z_s1[0];
			z_s2 <= z_s1;
		end
	end

	// Finish x exactly and classify the frame
	always_ff @(posedge clk) begin
		if (en) begin
			word_s3.z0 <= z_s2[0];
			word_s3.z1 <= z_s2[1];
			word_s3.z2 <= z_s2[2];
			word_s3.x0 <= 67'(p_s2[0]) - 67'(q_s2[0]);
			word_s3.x1 <= 67'(p_s2[1]) - 67'(q_s2[1]);
			word_s3.x2 <= 67'(p_s2[2]) - 67'(q_s2[2]);
			word_s3.degen <= (z_s2[0] == '0 && z_s2[1] == '0 && z_s2[2] == '0) ||
				(p_s2[0] == q_s2[0] && p_s2[1] == q_s2[1] && p_s2[2] == q_s2[2]);
			word_s3.vert <= z_s2[0] == '0 && z_s2[1] == '0;
		end
	end

endmodule

### sv/eafp_queue.sv
module eafp_queue import eafp_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	output logic   push_ready,
	input  frame_t push_word,
	output logic   pop_valid,
	input  logic   pop_ready,
	output frame_t pop_word
);

	localparam int PW = $clog2(QDEPTH);

	frame_t mem [QDEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0] cnt_q;
	logic push, pop;

	assign push_ready = cnt_q != (PW+1)'(QDEPTH);
	assign pop_valid = cnt_q != '0;
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_word = mem[rd_q];

	// Store a word
	always_ff @(posedge clk) begin
		if (push) mem[wr_q] <= push_word;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(QDEPTH)) else $error("queue count out of range");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("queue count missed a push");

endmodule

### sv/eafp_isqrt.sv
module eafp_isqrt import eafp_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [61:0] rad,
	output logic [30:0] root
);

	logic [32:0] rem_s [SQ_STAGES];
	logic [30:0] rt_s [SQ_STAGES];
	logic [61:0] rad_s [SQ_STAGES];

	// One result bit per stage, restoring form
	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_step
		logic [32:0] rem_in;
		logic [30:0] rt_in;
		logic [61:0] rad_in;
		logic [32:0] cur, trial;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign rt_in = '0;
			assign rad_in = rad;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign rt_in = rt_s[k-1];
			assign rad_in = rad_s[k-1];
		end

		assign cur = {rem_in[30:0], rad_in[61:60]};
		assign trial = {rt_in, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				if (cur >= trial) begin
					rem_s[k] <= cur - trial;
					rt_s[k] <= {rt_in[29:0], 1'b1};
				end else begin
					rem_s[k] <= cur;
					rt_s[k] <= {rt_in[29:0], 1'b0};
				end
				rad_s[k] <= {rad_in[59:0], 2'b00};
			end
		end
	end

	assign root = rt_s[SQ_STAGES-1];

endmodule

### sv/eafp_atan2.sv
module eafp_atan2 import eafp_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [63:0] y,
	input  logic signed [63:0] x,
	output logic signed [15:0] ang
);

	logic [63:0] ux_s1, uy_s1, ux_s2, uy_s2;
	logic xn_s1, yn_s1, xn_s2, yn_s2;
	logic [6:0] lz_s2;
	logic zero_s2, zero_s3;
	logic [63:0] nx, nyv;
	logic signed [33:0] sx, sy, x0, y0;
	logic signed [27:0] a0;
	logic signed [33:0] x_s3, y_s3;
	logic signed [27:0] a_s3;
	logic signed [33:0] cx_s [CORDIC_STEPS];
	logic signed [33:0] cy_s [CORDIC_STEPS];
	logic signed [27:0] ca_s [CORDIC_STEPS];
	logic cz_s [CORDIC_STEPS];
	logic signed [27:0] acc;
	logic [27:0] amag;
	logic [16:0] rnd;
	logic [14:0] rsat;
	logic signed [15:0] ang_s;

	// Take magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			ux_s1 <= x[63] ? 64'(-x) : 64'(x);
			uy_s1 <= y[63] ? 64'(-y) : 64'(y);
			xn_s1 <= x[63];
			yn_s1 <= y[63];
		end
	end

	// Find the common normalizing shift
	always_ff @(posedge clk) begin
		if (en) begin
			lz_s2 <= lzc65({ux_s1 | uy_s1, 1'b0});
			zero_s2 <= (ux_s1 | uy_s1) == '0;
			ux_s2 <= ux_s1;
			uy_s2 <= uy_s1;
			xn_s2 <= xn_s1;
			yn_s2 <= yn_s1;
		end
	end

	// Scale to AXIS_BITS, restore signs, fold the left half plane
	always_comb begin
		nx = ux_s2 << lz_s2;
		nyv = uy_s2 << lz_s2;
		sx = xn_s2 ? -$signed(34'(nx[63 -: AXIS_BITS])) : $signed(34'(nx[63 -: AXIS_BITS]));
		sy = yn_s2 ? -$signed(34'(nyv[63 -: AXIS_BITS])) : $signed(34'(nyv[63 -: AXIS_BITS]));
		if (sx[33]) begin
			a0 = sy[33] ? -PI_A24 : PI_A24;
			x0 = -sx;
			y0 = -sy;
		end else begin
			a0 = '0;
			x0 = sx;
			y0 = sy;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3 <= x0;
			y_s3 <= y0;
			a_s3 <= a0;
			zero_s3 <= zero_s2;
		end
	end

	// Vectoring iterations, one per stage
	for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot
		logic signed [33:0] xi, yi;
		logic signed [27:0] ai;
		logic zi;

		if (k == 0) begin : g_first
			assign xi = x_s3;
			assign yi = y_s3;
			assign ai = a_s3;
			assign zi = zero_s3;
		end else begin : g_next
			assign xi = cx_s[k-1];
			assign yi = cy_s[k-1];
			assign ai = ca_s[k-1];
			assign zi = cz_s[k-1];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!yi[33]) begin
					cx_s[k] <= xi + (yi >>> k);
					cy_s[k] <= yi - (xi >>> k);
					ca_s[k] <= ai + $signed(28'(ATAN_TAB[k]));
				end else begin
					cx_s[k] <= xi - (yi >>> k);
					cy_s[k] <= yi + (xi >>> k);
					ca_s[k] <= ai - $signed(28'(ATAN_TAB[k]));
				end
				cz_s[k] <= zi;
			end
		end
	end

	// Round half away from zero to Q3.13 and saturate at pi
	always_comb begin
		acc = ca_s[CORDIC_STEPS-1];
		amag = acc[27] ? 28'(-acc) : 28'(acc);
		rnd = 17'((29'(amag) + 29'd1024) >> 11);
		rsat = (rnd > 17'(PI_Q13)) ? PI_Q13 : rnd[14:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (cz_s[CORDIC_STEPS-1]) ang_s <= '0;
			else if (acc[27]) ang_s <= -$signed({1'b0, rsat});
			else ang_s <= $signed({1'b0, rsat});
		end
	end

	assign ang = ang_s;

endmodule

### sv/eafp_back.sv
module eafp_back import eafp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  frame_t             word,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] alpha,
	output logic        [14:0] beta,
	output logic signed [15:0] gamma,
	output logic               degenerate
);

	typedef struct packed {
		logic v;
		logic degen;
		logic vert;
		logic zpos;
	} flag_t;

	typedef struct packed {
		logic signed [62:0]     ny;
		logic signed [ZR_W-1:0] xr2;
		logic signed [ZR_W-1:0] zr2;
		logic signed [63:0]     gy;
		logic signed [63:0]     gx;
	} side_t;

	logic en, take;
	flag_t fl_q [BACK_LAT];
	flag_t fl_end;
	side_t dl_q [SQ_STAGES];
	side_t dl_end;

	logic signed [32:0] zw [3];
	logic signed [66:0] xw [3];
	logic [31:0] zm_s1 [3];
	logic zn_s1 [3];
	logic [64:0] xm_s1 [3];
	logic xn_s1 [3];
	logic signed [32:0] z0_s1, z1_s1;

	logic [31:0] zm_s2 [3];
	logic zn_s2 [3];
	logic [64:0] xm_s2 [3];
	logic xn_s2 [3];
	logic [6:0] lzz_s2, lzx_s2;
	logic signed [32:0] z0_s2, z1_s2;

	logic [31:0] zsh [3];
	logic [64:0] xsh [3];
	logic signed [ZR_W-1:0] zr_s3 [3];
	logic signed [ZR_W-1:0] xr_s3 [3];
	logic signed [32:0] z0_s3, z1_s3;

	logic signed [61:0] pz [3];
	logic signed [61:0] pd, pe;
	logic [59:0] sq_s4 [3];
	logic signed [61:0] d_s4, e_s4;
	logic signed [ZR_W-1:0] xr2_s4, zr2_s4;
	logic signed [63:0] gy_s4, gx_s4;

	logic [60:0] sxy_s5;
	logic [61:0] tot_s5;
	logic signed [62:0] ny_s5;
	logic signed [ZR_W-1:0] xr2_s5, zr2_s5;
	logic signed [63:0] gy_s5, gx_s5;

	logic [30:0] rxy, rall;
	logic signed [62:0] pa;
	logic signed [63:0] ay_s37, ax_s37, by_s37, bx_s37, gy_s37, gx_s37;
	logic signed [15:0] ang_a, ang_b, ang_g;

	logic out_valid_q;
	logic signed [15:0] alpha_q, gamma_q;
	logic [14:0] beta_q;
	logic degen_q;

	// Stall everything while the output word waits
	assign en = !out_valid_q || out_ready;
	assign q_ready = en;
	assign take = q_valid && en;
	assign fl_end = fl_q[BACK_LAT-1];
	assign dl_end = dl_q[SQ_STAGES-1];

	// Carry valid and frame class alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BACK_LAT; i++) fl_q[i] <= '0;
		end else if (en) begin
			fl_q[0] <= '{v: take, degen: word.degen, vert: word.vert,
				zpos: !word.z2[32] && word.z2 != '0};
			for (int i = 1; i < BACK_LAT; i++) fl_q[i] <= fl_q[i-1];
		end
	end

	// Split axes into sign and magnitude
	always_comb begin
		zw[0] = word.z0;
		zw[1] = word.z1;
		zw[2] = word.z2;
		xw[0] = word.x0;
		xw[1] = word.x1;
		xw[2] = word.x2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				zm_s1[i] <= 32'(zw[i][32] ? -zw[i] : zw[i]);
				zn_s1[i] <= zw[i][32];
				xm_s1[i] <= 65'(xw[i][66] ? -xw[i] : xw[i]);
				xn_s1[i] <= xw[i][66];
			end
			z0_s1 <= word.z0;
			z1_s1 <= word.z1;
		end
	end

	// Find each axis' normalizing shift
	always_ff @(posedge clk) begin
		if (en) begin
			lzz_s2 <= lzc65({zm_s1[0] | zm_s1[1] | zm_s1[2], 33'b0});
			lzx_s2 <= lzc65(xm_s1[0] | xm_s1[1] | xm_s1[2]);
			zm_s2 <= zm_s1;
			zn_s2 <= zn_s1;
			xm_s2 <= xm_s1;
			xn_s2 <= xn_s1;
			z0_s2 <= z0_s1;
			z1_s2 <= z1_s1;
		end
	end

	// Scale axes to AXIS_BITS, truncating magnitudes
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			zsh[i] = zm_s2[i] << lzz_s2;
			xsh[i] = xm_s2[i] << lzx_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				zr_s3[i] <= zn_s2[i] ? -$signed(ZR_W'(zsh[i][31 -: AXIS_BITS]))
					: $signed(ZR_W'(zsh[i][31 -: AXIS_BITS]));
				xr_s3[i] <= xn_s2[i] ? -$signed(ZR_W'(xsh[i][64 -: AXIS_BITS]))
					: $signed(ZR_W'(xsh[i][64 -: AXIS_BITS]));
			end
			z0_s3 <= z0_s2;
			z1_s3 <= z1_s2;
		end
	end

	// Squares and the y-axis z component products; pick gamma operands
	always_comb begin
		for (int i = 0; i < 3; i++) pz[i] = zr_s3[i] * zr_s3[i];
		pd = zr_s3[0] * xr_s3[1];
		pe = zr_s3[1] * xr_s3[0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) sq_s4[i] <= pz[i][59:0];
			d_s4 <= pd;
			e_s4 <= pe;
			xr2_s4 <= xr_s3[2];
			zr2_s4 <= zr_s3[2];
			if (fl_q[2].vert) begin
				gy_s4 <= 64'(xr_s3[1]);
				gx_s4 <= 64'(xr_s3[0]);
			end else begin
				gy_s4 <= -64'(z0_s3);
				gx_s4 <= 64'(z1_s3);
			end
		end
	end

	// Sum the squares and finish ny
	always_ff @(posedge clk) begin
		if (en) begin
			sxy_s5 <= 61'(sq_s4[0]) + 61'(sq_s4[1]);
			tot_s5 <= 62'(sq_s4[0]) + 62'(sq_s4[1]) + 62'(sq_s4[2]);
			ny_s5 <= 63'(d_s4) - 63'(e_s4);
			xr2_s5 <= xr2_s4;
			zr2_s5 <= zr2_s4;
			gy_s5 <= gy_s4;
			gx_s5 <= gx_s4;
		end
	end

	eafp_isqrt u_sq_xy (
		.clk  (clk),
		.en   (en),
		.rad  ({1'b0, sxy_s5}),
		.root (rxy)
	);

	eafp_isqrt u_sq_all (
		.clk  (clk),
		.en   (en),
		.rad  (tot_s5),
		.root (rall)
	);

	// Hold side operands while the square roots run
	always_ff @(posedge clk) begin
		if (en) begin
			dl_q[0] <= '{ny: ny_s5, xr2: xr2_s5, zr2: zr2_s5, gy: gy_s5, gx: gx_s5};
			for (int i = 1; i < SQ_STAGES; i++) dl_q[i] <= dl_q[i-1];
		end
	end

	// Scale the x axis z component by the z axis length
	assign pa = dl_end.xr2 * $signed({1'b0, rall});

	always_ff @(posedge clk) begin
		if (en) begin
			ay_s37 <= 64'(pa);
			ax_s37 <= -64'(dl_end.ny);
			by_s37 <= $signed({33'b0, rxy});
			bx_s37 <= 64'(dl_end.zr2);
			gy_s37 <= dl_end.gy;
			gx_s37 <= dl_end.gx;
		end
	end

	eafp_atan2 u_at_a (
		.clk (clk),
		.en  (en),
		.y   (ay_s37),
		.x   (ax_s37),
		.ang (ang_a)
	);

	eafp_atan2 u_at_b (
		.clk (clk),
		.en  (en),
		.y   (by_s37),
		.x   (bx_s37),
		.ang (ang_b)
	);

	eafp_atan2 u_at_g (
		.clk (clk),
		.en  (en),
		.y   (gy_s37),
		.x   (gx_s37),
		.ang (ang_g)
	);

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= fl_end.v;
	end

	// Select angles by frame class
	always_ff @(posedge clk) begin
		if (en) begin
			degen_q <= fl_end.degen;
			if (fl_end.degen) begin
				alpha_q <= '0;
				beta_q <= '0;
				gamma_q <= '0;
			end else if (fl_end.vert) begin
				alpha_q <= '0;
				beta_q <= fl_end.zpos ? 15'd0 : PI_Q13;
				gamma_q <= -ang_g;
			end else begin
				alpha_q <= ang_a;
				beta_q <= ang_b[15] ? 15'd0 : ang_b[14:0];
				gamma_q <= -ang_g;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign alpha = alpha_q;
	assign beta = beta_q;
	assign gamma = gamma_q;
	assign degenerate = degen_q;

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> alpha == '0 && beta == '0 && gamma == '0)
		else $error("degenerate frame with nonzero angle");

	a_take_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> fl_q[0].v) else $error("popped word not tracked");

endmodule

### sv/euler_angles_from_three_points.sv
// Euler angles of the local frame spanned by three Q16.16 points (mid, up, side):
// z = up - mid, x = (side - mid) x z, y = z x x. Angles alpha, beta, gamma come out
// in radians as Q3.13, with beta in [0, pi]. A zero-length axis sets degenerate and
// zeroes all angles; when z has no xy part, alpha is 0 and beta is 0 or pi. The block
// takes one word per clock while it is not stalled and returns one result word per input word,
// in order. The exact cross product is registered in the front, the queue follows, and then
// the angle pipeline with its output register, whose depth is set by the 31-stage square
// root and the 24-step CORDIC units. A four-entry queue between the front and the angle
// pipeline lets input keep flowing for a few words while the output stalls.
module euler_angles_from_three_points import eafp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] mid_x,
	input  logic signed [31:0] mid_y,
	input  logic signed [31:0] mid_z,
	input  logic signed [31:0] up_x,
	input  logic signed [31:0] up_y,
	input  logic signed [31:0] up_z,
	input  logic signed [31:0] side_x,
	input  logic signed [31:0] side_y,
	input  logic signed [31:0] side_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] alpha,
	output logic        [14:0] beta,
	output logic signed [15:0] gamma,
	output logic               degenerate
);

	logic f_valid, f_ready, b_valid, b_ready;
	frame_t f_word, b_word;

	eafp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mid_x    (mid_x),
		.mid_y    (mid_y),
		.mid_z    (mid_z),
		.up_x     (up_x),
		.up_y     (up_y),
		.up_z     (up_z),
		.side_x   (side_x),
		.side_y   (side_y),
		.side_z   (side_z),
		.q_valid  (f_valid),
		.q_ready  (f_ready),
		.word     (f_word)
	);

	eafp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_word  (f_word),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_word   (b_word)
	);

	eafp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (b_valid),
		.q_ready    (b_ready),
		.word       (b_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.alpha      (alpha),
		.beta       (beta),
		.gamma      (gamma),
		.degenerate (degenerate)
	);

endmodule

### test/tb_euler_angles_from_three_points.sv
`timescale 1ns / 1ps

module tb_euler_angles_from_three_points import eafp_pkg::*;;

	typedef int pts_t [9];

	typedef struct {
		logic signed [15:0] alpha;
		logic        [14:0] beta;
		logic signed [15:0] gamma;
		logic               degen;
	} angles_t;

	typedef struct {
		pts_t    p;
		bit      known;
		angles_t want;
	} row_t;

	localparam int IMAX = 32'h7fffffff;
	localparam int IMIN = 32'h80000000;
	localparam int ONE = 65536;
	localparam int N_RANDOM = 1830;
	localparam int STALL_LIMIT = 5000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [31:0] mid_x = 0, mid_y = 0, mid_z = 0;
	logic signed [31:0] up_x = 0, up_y = 0, up_z = 0;
	logic signed [31:0] side_x = 0, side_y = 0, side_z = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [15:0] alpha;
	logic [14:0] beta;
	logic signed [15:0] gamma;
	logic degenerate;

	angles_t angle_q [$];
	int errors = 0;
	int quiet_cycles = 0;
	bit calm = 0;

	euler_angles_from_three_points uut (.*);

	always #5 clk = ~clk;

	// Directed words: degenerate ones carry their known result
	row_t rows [] = '{
		'{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 1}},
		'{'{5, 5, 5, 5, 5, 5, 9, -3, 7}, 1, '{0, 0, 0, 1}},
		'{'{1, 2, 3, 4, -5, 6, 1, 2, 3}, 1, '{0, 0, 0, 1}},
		'{'{0, 0, 0, 1, 2, 3, 2, 4, 6}, 1, '{0, 0, 0, 1}},
		'{'{IMIN, IMIN, IMIN, IMAX, IMAX, IMAX, IMIN, IMIN, IMIN}, 1, '{0, 0, 0, 1}},
		'{'{IMIN, IMIN, IMIN, IMAX, IMAX, IMAX, IMAX, IMIN, IMAX}, 0, '{0, 0, 0, 0}},
		'{'{IMAX, IMAX, IMAX, IMIN, IMIN, IMIN, 0, 0, IMIN}, 0, '{0, 0, 0, 0}},
		'{'{IMAX, IMIN, 0, IMIN, IMAX, IMAX, IMIN, IMIN, IMAX}, 0, '{0, 0, 0, 0}},
		'{'{0, 0, 0, 0, 0, ONE, ONE, 0, 0}, 0, '{0, 0, 0, 0}},
		'{'{0, 0, 0, 0, 0, -ONE, ONE, 0, 0}, 0, '{0, 0, 0, 0}},
		'{'{0, 0, 0, 0, 0, IMAX, IMIN, IMAX, 0}, 0, '{0, 0, 0, 0}},
		'{'{3, -7, 0, 3, -7, IMIN, 0, 1, 0}, 0, '{0, 0, 0, 0}},
		'{'{0, 0, 0, 0, ONE, 0, ONE, 0, 0}, 0, '{0, 0, 0, 0}},
		'{'{0, 0, 0, -ONE, 0, 0, 0, 0, ONE}, 0, '{0, 0, 0, 0}},
		'{'{0, 0, 0, 1, 0, 0, 0, 1, 0}, 0, '{0, 0, 0, 0}},
		'{'{0, 0, 0, 0, -1, 0, 0, 0, 1}, 0, '{0, 0, 0, 0}},
		'{'{0, 0, 0, 1, 1, 1, -1, 1, 0}, 0, '{0, 0, 0, 0}},
		'{'{-4, 9, 2, -4, 8, 2, 100, 9, 2}, 0, '{0, 0, 0, 0}},
		'{'{0, 0, 0, -1, -1, -1, 1, -1, 0}, 0, '{0, 0, 0, 0}},
		'{'{IMIN, 0, IMAX, IMAX, 0, IMIN, 0, IMAX, 0}, 0, '{0, 0, 0, 0}}
	};

	function automatic int bit_count(logic [67:0] v);
		int n;
		n = 0;
		for (int i = 0; i < 68; i++)
			if (v[i]) n = i + 1;
		return n;
	endfunction

	// Bring the largest magnitude of an axis to exactly 30 bits, truncating
	function automatic void norm_axis(input logic signed [67:0] v [3], output longint r [3]);
		logic [67:0] mag [3];
		int len;
		len = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = v[i] < 0 ? -v[i] : v[i];
			if (bit_count(mag[i]) > len) len = bit_count(mag[i]);
		end
		for (int i = 0; i < 3; i++) begin
			if (len > AXIS_BITS) mag[i] = mag[i] >> (len - AXIS_BITS);
			else mag[i] = mag[i] << (AXIS_BITS - len);
			r[i] = v[i] < 0 ? -longint'(mag[i]) : longint'(mag[i]);
		end
	endfunction

	function automatic longint floor_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	// Vectoring CORDIC angle of (x, y), rounded to Q3.13
	function automatic int cordic_angle(longint y, longint x);
		longint unsigned ux, uy, m, r;
		longint xs, ys, dx, dy, acc;
		int len;
		ux = x < 0 ? -x : x;
		uy = y < 0 ? -y : y;
		m = ux > uy ? ux : uy;
		acc = 0;
		if (m == 0) return 0;
		len = 0;
		for (int i = 0; i < 64; i++)
			if (m[i]) len = i + 1;
		if (len > AXIS_BITS) begin
			ux = ux >> (len - AXIS_BITS);
			uy = uy >> (len - AXIS_BITS);
		end else begin
			ux = ux << (AXIS_BITS - len);
			uy = uy << (AXIS_BITS - len);
		end
		xs = x < 0 ? -longint'(ux) : longint'(ux);
		ys = y < 0 ? -longint'(uy) : longint'(uy);
		if (xs < 0) begin
			acc = ys >= 0 ? longint'(PI_A24) : -longint'(PI_A24);
			xs = -xs;
			ys = -ys;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = ys >>> i;
			dy = xs >>> i;
			if (ys >= 0) begin
				xs = xs + dx;
				ys = ys - dy;
				acc = acc + longint'(ATAN_TAB[i]);
			end else begin
				xs = xs - dx;
				ys = ys + dy;
				acc = acc - longint'(ATAN_TAB[i]);
			end
		end
		r = ((acc < 0 ? -acc : acc) + 1024) >> 11;
		if (r > PI_Q13) r = PI_Q13;
		return acc < 0 ? -int'(r) : int'(r);
	endfunction

	// Expected angles of the frame spanned by mid, up and side
	function automatic angles_t euler_of_points(pts_t p);
		angles_t res;
		logic signed [67:0] z [3], s [3], xa [3];
		longint zr [3], xr [3], nz, ny, sxy;
		int b;
		for (int i = 0; i < 3; i++) begin
			z[i] = 68'(signed'(p[3 + i])) - 68'(signed'(p[i]));
			s[i] = 68'(signed'(p[6 + i])) - 68'(signed'(p[i]));
		end
		xa[0] = s[1] * z[2] - s[2] * z[1];
		xa[1] = s[2] * z[0] - s[0] * z[2];
		xa[2] = s[0] * z[1] - s[1] * z[0];
		res = '{0, 0, 0, 0};
		res.degen = (z[0] == 0 && z[1] == 0 && z[2] == 0) ||
			(xa[0] == 0 && xa[1] == 0 && xa[2] == 0);
		if (res.degen) return res;
		norm_axis(z, zr);
		norm_axis(xa, xr);
		if (z[0] != 0 || z[1] != 0) begin
			sxy = zr[0] * zr[0] + zr[1] * zr[1];
			nz = floor_sqrt(sxy + zr[2] * zr[2]);
			ny = zr[0] * xr[1] - zr[1] * xr[0];
			res.alpha = 16'(cordic_angle(xr[2] * nz, -ny));
			b = cordic_angle(floor_sqrt(sxy), zr[2]);
			res.beta = b < 0 ? 15'd0 : 15'(b);
			res.gamma = 16'(-cordic_angle(-longint'(z[0]), longint'(z[1])));
		end else begin
			res.beta = z[2] > 0 ? 15'd0 : PI_Q13;
			res.gamma = 16'(-cordic_angle(xr[1], xr[0]));
		end
		return res;
	endfunction

	function automatic int rand_coord(int span);
		return span == 0 ? int'($urandom) : $urandom_range(0, 2 * span) - span;
	endfunction

	// Random triple: mostly well-formed frames, with vertical and degenerate shapes mixed in
	function automatic pts_t rand_points();
		pts_t p;
		int shape, span, k;
		shape = $urandom_range(0, 19);
		span = shape[0] ? 0 : (shape[1] ? 40 : 3 * ONE);
		for (int i = 0; i < 9; i++) p[i] = rand_coord(span);
		case (shape)
			0, 1: begin
				p[3] = p[0];
				p[4] = p[1];
			end
			2: for (int i = 0; i < 3; i++) p[3 + i] = p[i];
			3: for (int i = 0; i < 3; i++) p[6 + i] = p[i];
			4: begin
				k = $urandom_range(0, 6) - 3;
				for (int i = 0; i < 3; i++) p[6 + i] = p[i] + k * (p[3 + i] - p[i]);
			end
			5: for (int i = 0; i < 9; i++)
				p[i] = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? IMAX : IMIN) : p[i];
			default: ;
		endcase
		return p;
	endfunction

	// Drive one word and hold it until taken
	task automatic send_word(pts_t p, bit known, angles_t want);
		while (!calm && $urandom_range(0, 99) < 31) begin
			in_valid = 0;
			@(negedge clk);
		end
		{mid_x, mid_y, mid_z} = {p[0], p[1], p[2]};
		{up_x, up_y, up_z} = {p[3], p[4], p[5]};
		{side_x, side_y, side_z} = {p[6], p[7], p[8]};
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		angle_q.insert(angle_q.size(), known ? want : euler_of_points(p));
		@(negedge clk);
	endtask

	// Stall the result side at random
	always @(negedge clk)
		out_ready = calm || $urandom_range(0, 99) >= 31;

	// Compare each result word with the oldest expectation
	always @(posedge clk) begin
		angles_t w;
		if (arst_n && out_valid && out_ready) begin
			if (angle_q.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				w = angle_q.pop_front();
				if (alpha !== w.alpha) begin
					$error("alpha: expected %0d, got %0d", w.alpha, alpha);
					errors++;
				end
				if (beta !== w.beta) begin
					$error("beta: expected %0d, got %0d", w.beta, beta);
					errors++;
				end
				if (gamma !== w.gamma) begin
					$error("gamma: expected %0d, got %0d", w.gamma, gamma);
					errors++;
				end
				if (degenerate !== w.degen) begin
					$error("degenerate: expected %0d, got %0d", w.degen, degenerate);
					errors++;
				end
			end
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		angles_t none;
		none = '{0, 0, 0, 0};
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		foreach (rows[i]) send_word(rows[i].p, rows[i].known, rows[i].want);
		for (int n = 0; n < N_RANDOM; n++) begin
			calm = n >= 700 && n < 1000;
			send_word(rand_points(), 0, none);
		end
		calm = 0;
		in_valid = 0;
		while (angle_q.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
